// ===== design/edt_pkg.sv =====
// Shared types, codes and constants of the transposition-aware edit distance block.
// No dependencies; the interfaces and the top level import this package.
package edt_pkg;

  // Field widths of the input and result beats.
  localparam int ACTION_W  = 2;
  localparam int SYM_W     = 8;
  localparam int DIST_W    = 12;
  localparam int COST_W    = 4;
  localparam int CFG_IDX_W = 2;

  // Default longest string and the saturation point of the result.
  localparam int MAX_LEN_DEF = 64;
  localparam int DIST_MAX    = 4095;

  // Cost register values after reset.
  localparam logic [COST_W-1:0] INS_COST_RST   = 4'd1;
  localparam logic [COST_W-1:0] DEL_COST_RST   = 4'd1;
  localparam logic [COST_W-1:0] SUB_COST_RST   = 4'd1;
  localparam logic [COST_W-1:0] TRANS_COST_RST = 4'd2;

  // Action codes carried by an input beat.
  typedef enum logic [ACTION_W-1:0] {
    ACT_FIRST   = 2'd0,
    ACT_SECOND  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INSERT    = 2'd0,
    CFG_DELETE    = 2'd1,
    CFG_SUBST     = 2'd2,
    CFG_TRANSPOSE = 2'd3
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL
  } state_e;

  // Beat payloads.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SYM_W-1:0]    symbol;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } result_t;

endpackage

// ===== design/edt_item_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on edt_pkg for the payload types.
interface edt_item_if;
  import edt_pkg::*;

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface edt_result_if;
  import edt_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/edt_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module edt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/edit_distance_with_transpose.sv =====
// Top level of the optimal string alignment (restricted Damerau) edit distance block.
// Depends on edt_pkg, the edt_item_if / edt_result_if interfaces and edt_ram.

// Input beats append a byte to the first or second string (taken back to back while no
// compute runs) or start a compute. A compute of strings of lengths n and m, both nonzero,
// sweeps the cost table row by row: a setup state per row, then one cell per cycle. The
// row memory has a single read and write port and holds the two previous rows packed side
// by side. If either string is empty the result is ready in the cycle after the compute
// beat. The result then waits in an output register while new strings load; a compute is
// taken only once that register is free. After a compute both strings and the
// dropped-character flag are cleared. Characters past MaxLen are dropped and flagged.
// Cost registers must be written only while no compute runs; the block does not enforce it.
module edit_distance_with_transpose #(
  parameter int MaxLen = edt_pkg::MAX_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [edt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [edt_pkg::COST_W-1:0]     cfg_data_i,
  edt_item_if.sink                       item_i,
  edt_result_if.source                   result_o
);
  import edt_pkg::*;

  // Length counters hold 0..MaxLen; addresses span 0..MaxLen-1.
  localparam int LW     = $clog2(MaxLen + 1);
  localparam int AW     = $clog2(MaxLen);
  localparam int CW_RAW = COST_W + $clog2(2 * MaxLen + 1);
  localparam int CW     = (CW_RAW > DIST_W) ? CW_RAW : DIST_W;

  state_e state_q, state_d;

  logic [COST_W-1:0] ins_q, del_q, sub_q, trn_q;
  logic [LW-1:0]     len_a_q, len_b_q;
  logic              ovf_q;
  logic [LW-1:0]     row_q, col_q;
  logic [LW-1:0]     row_m1, col_m1;
  logic [CW-1:0]     left_q, diag_q, u2a_q, u2b_q, rowbase_q, colacc_q;
  logic [SYM_W-1:0]  a_prev_q, b_prev_q;
  logic              out_valid_q;
  result_t           out_q;

  logic              accept, out_take, out_free;
  logic              is_first, is_second, is_compute, empty_job;
  logic              last_col, last_row;

  // RAM controls.
  logic              a_we, b_we, a_re, bc_re, c_we;
  logic [AW-1:0]     a_waddr, b_waddr, a_raddr, bc_raddr, c_waddr;
  logic [SYM_W-1:0]  a_rdata, b_rdata;
  logic [2*CW-1:0]   c_wdata, c_rdata;

  // Cell datapath.
  logic [CW-1:0]     up_j, up2_j, cand_ins, cand_del, cand_sub, cand_trn, m1, m2, best;
  logic              trans_ok;
  logic [CW-1:0]     empty_dist;
  logic [DIST_W-1:0] best_sat, empty_sat;

  // Handshake decode. Loads pass a waiting result; a compute needs the result register free.
  assign out_take   = out_valid_q && result_o.ready;
  assign out_free   = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == ST_IDLE) && (out_free || !is_compute);
  assign accept     = item_i.valid && item_i.ready;
  assign is_first   = item_i.payload.action == ACT_FIRST;
  assign is_second  = item_i.payload.action == ACT_SECOND;
  assign is_compute = item_i.payload.action == ACT_COMPUTE;
  assign empty_job  = (len_a_q == '0) || (len_b_q == '0);
  assign last_col   = col_q == len_b_q;
  assign last_row   = row_q == len_a_q;
  assign row_m1     = row_q - LW'(1);
  assign col_m1     = col_q - LW'(1);

  // String stores and the packed row store {row i-1, row i-2}.
  edt_ram #(.Width(SYM_W), .Depth(MaxLen)) u_ram_a (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(item_i.payload.symbol),
    .re_i(a_re), .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  edt_ram #(.Width(SYM_W), .Depth(MaxLen)) u_ram_b (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(item_i.payload.symbol),
    .re_i(bc_re), .raddr_i(bc_raddr), .rdata_o(b_rdata)
  );

  edt_ram #(.Width(2 * CW), .Depth(MaxLen)) u_ram_rows (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .re_i(bc_re), .raddr_i(bc_raddr), .rdata_o(c_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_compute && !empty_job) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        state_d = ST_CELL;
      end
      ST_CELL: begin
        if (last_col) begin
          state_d = last_row ? ST_IDLE : ST_ROW;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory controls per state. A row's reads never meet a pending write to the same
  // entry: a cell writes entry j-1 while reading entry j, and each row starts with a
  // setup state.
  always_comb begin
    a_we     = 1'b0;
    b_we     = 1'b0;
    a_re     = 1'b0;
    bc_re    = 1'b0;
    c_we     = 1'b0;
    a_waddr  = len_a_q[AW-1:0];
    b_waddr  = len_b_q[AW-1:0];
    a_raddr  = row_m1[AW-1:0];
    bc_raddr = '0;
    c_waddr  = row_m1[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        a_we = accept && is_first && (len_a_q != LW'(MaxLen));
        b_we = accept && is_second && (len_b_q != LW'(MaxLen));
      end
      ST_ROW: begin
        a_re  = 1'b1;
        bc_re = 1'b1;
      end
      ST_CELL: begin
        bc_re    = !last_col;
        bc_raddr = col_q[AW-1:0];
        c_we     = 1'b1;
        c_waddr  = col_m1[AW-1:0];
      end
      default: begin
        a_we = 1'b0;
      end
    endcase
  end

  // One table cell: column j of row i.
  assign up_j     = (row_q == LW'(1)) ? colacc_q : c_rdata[2*CW-1:CW];
  assign up2_j    = c_rdata[CW-1:0];
  assign cand_ins = left_q + CW'(ins_q);
  assign cand_del = up_j + CW'(del_q);
  assign cand_sub = diag_q + ((a_rdata == b_rdata) ? CW'(0) : CW'(sub_q));
  assign cand_trn = u2b_q + CW'(trn_q);
  assign trans_ok = (row_q != LW'(1)) && (col_q != LW'(1)) &&
                    (a_prev_q == b_rdata) && (a_rdata == b_prev_q);
  assign m1       = (cand_del < cand_ins) ? cand_del : cand_ins;
  assign m2       = (cand_sub < m1) ? cand_sub : m1;
  assign best     = (trans_ok && (cand_trn < m2)) ? cand_trn : m2;
  assign c_wdata  = {best, up_j};

  // Results: the full table, or the border when a string is empty.
  assign empty_dist = (len_a_q == '0) ? CW'(len_b_q) * CW'(ins_q) : CW'(len_a_q) * CW'(del_q);
  assign best_sat   = (best > CW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : best[DIST_W-1:0];
  assign empty_sat  = (empty_dist > CW'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                    : empty_dist[DIST_W-1:0];

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // Cost registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q <= INS_COST_RST;
      del_q <= DEL_COST_RST;
      sub_q <= SUB_COST_RST;
      trn_q <= TRANS_COST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INSERT:    ins_q <= cfg_data_i;
        CFG_DELETE:    del_q <= cfg_data_i;
        CFG_SUBST:     sub_q <= cfg_data_i;
        CFG_TRANSPOSE: trn_q <= cfg_data_i;
        default:       ins_q <= ins_q;
      endcase
    end
  end

  // Control state: sequencer, lengths, overflow flag, counters, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      ovf_q       <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && is_first) begin
            if (len_a_q != LW'(MaxLen)) len_a_q <= len_a_q + LW'(1);
            else                        ovf_q   <= 1'b1;
          end
          if (accept && is_second) begin
            if (len_b_q != LW'(MaxLen)) len_b_q <= len_b_q + LW'(1);
            else                        ovf_q   <= 1'b1;
          end
          if (accept && is_compute) begin
            if (empty_job) begin
              out_valid_q <= 1'b1;
              len_a_q     <= '0;
              len_b_q     <= '0;
              ovf_q       <= 1'b0;
            end else begin
              row_q <= LW'(1);
            end
          end
        end
        ST_ROW: begin
          col_q <= LW'(1);
        end
        ST_CELL: begin
          if (last_col) begin
            if (last_row) begin
              out_valid_q <= 1'b1;
              len_a_q     <= '0;
              len_b_q     <= '0;
              ovf_q       <= 1'b0;
            end else begin
              row_q <= row_q + LW'(1);
            end
          end else begin
            col_q <= col_q + LW'(1);
          end
        end
        default: begin
          row_q <= row_q;
        end
      endcase
    end
  end

  // Datapath registers of the row sweep and the result register.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        rowbase_q <= '0;
        if (accept && is_compute && empty_job) begin
          out_q.distance <= empty_sat;
          out_q.too_long <= ovf_q;
        end
      end
      ST_ROW: begin
        a_prev_q  <= a_rdata;
        diag_q    <= rowbase_q;
        left_q    <= rowbase_q + CW'(del_q);
        u2a_q     <= rowbase_q - CW'(del_q);
        rowbase_q <= rowbase_q + CW'(del_q);
        colacc_q  <= CW'(ins_q);
      end
      ST_CELL: begin
        left_q   <= best;
        diag_q   <= up_j;
        u2b_q    <= u2a_q;
        u2a_q    <= up2_j;
        b_prev_q <= b_rdata;
        colacc_q <= colacc_q + CW'(ins_q);
        if (last_col && last_row) begin
          out_q.distance <= best_sat;
          out_q.too_long <= ovf_q;
        end
      end
      default: begin
        left_q <= left_q;
      end
    endcase
  end

  // The result register is never loaded while it still holds an untaken result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL && last_col && last_row) |-> !out_valid_q)
    else $error("result register overwritten");

  // The sweep stays within the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |-> (col_q != '0) && (col_q <= len_b_q) &&
                             (row_q != '0) && (row_q <= len_a_q))
    else $error("cell index outside the table");

  // A compute never starts on empty strings, and lengths stay in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && state_d == ST_ROW) |=> (len_a_q != '0) && (len_b_q != '0))
    else $error("table sweep started on an empty string");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= LW'(MaxLen)) && (len_b_q <= LW'(MaxLen)))
    else $error("string length beyond capacity");

endmodule
